@@ sv/wats_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm table scheduler package
// Shared types, constants and the wildcard match function.
// ----------------------------------------------------------------------------
package wats_pkg;

	localparam int ENTRIES     = 16;
	localparam int IDX_W       = 4;
	localparam int TYPE_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int ACTIVE_W    = 5;
	localparam int HOLDOFF_W   = 5;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = HOLDOFF_W'(30);

	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = CFG_IDX_W'(1);

	// Calendar fields in their raw bit form; a field of all ones is a wildcard.
	typedef struct packed {
		logic [6:0] minute;
		logic [5:0] hour;
		logic [3:0] weekday;
		logic [5:0] day;
		logic [4:0] month;
	} wats_time_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  idx;
		wats_time_t        pattern;
		logic [TYPE_W-1:0] mtype;
	} wats_load_t;

	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [TYPE_W-1:0] mtype;
	} wats_hit_t;

	function automatic logic wats_match(input wats_time_t pat, input wats_time_t now);
		logic m;
		m = ((pat.month   == '1) || (pat.month   == now.month))   &&
		    ((pat.day     == '1) || (pat.day     == now.day))     &&
		    ((pat.weekday == '1) || (pat.weekday == now.weekday)) &&
		    ((pat.hour    == '1) || (pat.hour    == now.hour))    &&
		    ((pat.minute  == '1) || (pat.minute  == now.minute));
		return m;
	endfunction

endpackage
`default_nettype wire

@@ sv/wildcard_alarm_table_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard alarm table scheduler
// A load writes one alarm entry without raising busy, so the next item may
// follow at once. A tick holds busy while its token walks the row of 16
// cells, one cell per cycle, and the next item is taken once busy drops;
// fired words pass through the collector and the final one carries last. Reset
// clears every fired flag and holdoff count, sets active_entries to 0 and
// holdoff_limit to 30.
// ----------------------------------------------------------------------------
module wildcard_alarm_table_scheduler (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire                            kind,
	input  wire [3:0]                      entry_index,
	input  wire signed [4:0]               month,
	input  wire signed [5:0]               day,
	input  wire signed [3:0]               weekday,
	input  wire signed [5:0]               hour,
	input  wire signed [6:0]               minute,
	input  wire [7:0]                      message_type,
	output logic                           strobe,
	output logic [3:0]                     fired_index,
	output logic [7:0]                     fired_type,
	output logic                           last,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [wats_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [wats_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wats_pkg::*;

	logic [ACTIVE_W-1:0]  active_q;
	logic [HOLDOFF_W-1:0] limit_q;
	logic                 busy_q;
	logic                 accept;
	logic                 tick_acc;
	wats_time_t           now;
	wats_load_t           load;
	logic                 tok [ENTRIES+1];
	wats_time_t           tm  [ENTRIES+1];
	wats_hit_t            hits [ENTRIES];
	wats_hit_t            hit_any;

	assign accept   = start && !busy_q;
	assign tick_acc = accept && kind;

	assign now.month   = $unsigned(month);
	assign now.day     = $unsigned(day);
	assign now.weekday = $unsigned(weekday);
	assign now.hour    = $unsigned(hour);
	assign now.minute  = $unsigned(minute);

	assign load.we      = accept && !kind;
	assign load.idx     = entry_index;
	assign load.pattern = now;
	assign load.mtype   = message_type;

	assign tok[0] = tick_acc;
	assign tm[0]  = now;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		wats_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.my_idx (IDX_W'(g)),
			.load   (load),
			.active (active_q),
			.limit  (limit_q),
			.tok_i  (tok[g]),
			.time_i (tm[g]),
			.tok_o  (tok[g+1]),
			.time_o (tm[g+1]),
			.hit    (hits[g])
		);
	end

	// Only the cell holding the token can hit, so the hits merge by OR.
	always_comb begin
		hit_any = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_any = wats_hit_t'(hit_any | hits[i]);
		end
	end

	wats_collect u_collect (
		.clk         (clk),
		.arst_n      (arst_n),
		.hit         (hit_any),
		.done        (tok[ENTRIES]),
		.strobe      (strobe),
		.fired_index (fired_index),
		.fired_type  (fired_type),
		.last        (last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			active_q <= '0;
			limit_q  <= HOLDOFF_RESET;
		end else begin
			if (tick_acc) begin
				busy_q <= 1'b1;
			end else if (tok[ENTRIES]) begin
				busy_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ACTIVE:  active_q <= cfg_data;
					CFG_HOLDOFF: limit_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign busy      = busy_q;
	// A register write never lands on the edge that starts a scan.
	assign cfg_ready = !busy_q && !start;

endmodule
`default_nettype wire

@@ sv/wats_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm table cell
// Holds one alarm entry with its fired flag and holdoff count, evaluates the
// tick token as it passes and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module wats_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [wats_pkg::IDX_W-1:0]    my_idx,
	input  wire wats_pkg::wats_load_t    load,
	input  wire [wats_pkg::ACTIVE_W-1:0] active,
	input  wire [wats_pkg::HOLDOFF_W-1:0] limit,
	input  wire                          tok_i,
	input  wire wats_pkg::wats_time_t    time_i,
	output logic                         tok_o,
	output wats_pkg::wats_time_t         time_o,
	output wats_pkg::wats_hit_t          hit
);
	import wats_pkg::*;

	wats_time_t          pattern_q;
	logic [TYPE_W-1:0]   mtype_q;
	logic                flag_q;
	logic [HOLDOFF_W-1:0] count_q;
	logic                tok_q;
	wats_time_t          time_q;

	logic                 load_me;
	logic                 enabled;
	logic                 fire;
	logic [HOLDOFF_W:0]   count_inc;

	assign load_me   = load.we && (load.idx == my_idx);
	assign enabled   = tok_i && ({1'b0, my_idx} < active);
	assign fire      = enabled && !flag_q && wats_match(pattern_q, time_i);
	assign count_inc = {1'b0, count_q} + (HOLDOFF_W+1)'(1);

	always_ff @(posedge clk) begin
		if (load_me) begin
			pattern_q <= load.pattern;
			mtype_q   <= load.mtype;
		end
		time_q <= time_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= 1'b0;
			count_q <= '0;
			tok_q   <= 1'b0;
		end else begin
			tok_q <= tok_i;
			if (load_me) begin
				flag_q  <= 1'b0;
				count_q <= '0;
			end else if (enabled && flag_q) begin
				// A disarmed entry counts ticks and re-arms once past the limit.
				if (count_inc > {1'b0, limit}) begin
					flag_q  <= 1'b0;
					count_q <= '0;
				end else begin
					count_q <= count_inc[HOLDOFF_W-1:0];
				end
			end else if (fire) begin
				flag_q  <= 1'b1;
				count_q <= '0;
			end
		end
	end

	assign tok_o     = tok_q;
	assign time_o    = time_q;
	assign hit.valid = fire;
	assign hit.idx   = fire ? my_idx : '0;
	assign hit.mtype = fire ? mtype_q : '0;

endmodule
`default_nettype wire

@@ sv/wats_collect.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm result collector
// Holds back each hit by one so that the final word of a tick can be marked.
// ----------------------------------------------------------------------------
module wats_collect (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire wats_pkg::wats_hit_t     hit,
	input  wire                          done,
	output logic                         strobe,
	output logic [wats_pkg::IDX_W-1:0]   fired_index,
	output logic [wats_pkg::TYPE_W-1:0]  fired_type,
	output logic                         last
);
	import wats_pkg::*;

	wats_hit_t         pend_q;
	logic              pend_valid_q;
	logic              strobe_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TYPE_W-1:0] type_q;
	logic              last_q;
	logic              emit;

	// A pending word leaves when a newer hit arrives or when the scan ends.
	assign emit = pend_valid_q && (hit.valid || done);

	always_ff @(posedge clk) begin
		if (hit.valid) begin
			pend_q <= hit;
		end
		if (emit) begin
			idx_q  <= pend_q.idx;
			type_q <= pend_q.mtype;
			last_q <= !hit.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (hit.valid) begin
				pend_valid_q <= 1'b1;
			end else if (done) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	assign strobe      = strobe_q;
	assign fired_index = idx_q;
	assign fired_type  = type_q;
	assign last        = last_q;

endmodule
`default_nettype wire

@@ sv/wats_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Alarm table scheduler checker
// Port-level properties of the tick scan and its result words.
// ----------------------------------------------------------------------------
module wats_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire kind,
	input wire strobe,
	input wire last
);

	// An accepted tick starts a scan.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && kind |=> busy)
		else $error("tick accepted without starting a scan");

	// A word that is not the final one comes while the scan still runs.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final word outside a scan");

	// Nothing follows the final word of a tick straight away.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("word directly after the final word");

	// Words appear only during a scan or in the cycle just after it.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !strobe)
		else $error("word while idle");

endmodule

bind wildcard_alarm_table_scheduler wats_checker u_wats_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.kind   (kind),
	.strobe (strobe),
	.last   (last)
);
`default_nettype wire

@@ bench/tb_wildcard_alarm_table_scheduler.sv @@
// ----------------------------------------------------------------------------
// Testbench for the wildcard alarm table scheduler
// Loads alarm entries and sends time ticks through the start/busy port, with
// random gaps between words. A model of the alarm table inside the bench works
// out which entries fire on each tick; every fired word from the block is
// compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_wildcard_alarm_table_scheduler;
	import wats_pkg::*;

	localparam bit KIND_LOAD = 1'b0;
	localparam bit KIND_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_WORDS = 72;

	typedef struct packed {
		logic              kind;
		logic [IDX_W-1:0]  slot;
		wats_time_t        t;
		logic [TYPE_W-1:0] mtype;
	} alarm_word_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [TYPE_W-1:0] mtype;
		logic              last;
	} alarm_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = 1'b0;
	logic [3:0] entry_index = '0;
	logic [4:0] month = '0;
	logic [5:0] day = '0;
	logic [3:0] weekday = '0;
	logic [5:0] hour = '0;
	logic [6:0] minute = '0;
	logic [7:0] message_type = '0;
	logic strobe;
	logic [3:0] fired_index;
	logic [7:0] fired_type;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Mirror of the alarm table and its registers.
	wats_time_t pat_tbl[ENTRIES];
	logic [TYPE_W-1:0] type_tbl[ENTRIES];
	bit fired_tbl[ENTRIES];
	logic [HOLDOFF_W-1:0] hold_tbl[ENTRIES];
	logic [ACTIVE_W-1:0] active_reg = '0;
	logic [HOLDOFF_W-1:0] holdoff_reg = HOLDOFF_RESET;

	alarm_hit_t fired_due[$];
	alarm_hit_t head;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit no_gaps = 1'b0;

	wildcard_alarm_table_scheduler DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.entry_index(entry_index), .month(month), .day(day), .weekday(weekday),
		.hour(hour), .minute(minute), .message_type(message_type),
		.strobe(strobe), .fired_index(fired_index), .fired_type(fired_type),
		.last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit field_ok(logic [6:0] stored, logic [6:0] now, logic [6:0] ones);
		return (stored == ones) || (stored == now);
	endfunction

	function automatic bit alarm_due(wats_time_t p, wats_time_t t);
		return field_ok(7'(p.month), 7'(t.month), 7'h1F) &&
		       field_ok(7'(p.day), 7'(t.day), 7'h3F) &&
		       field_ok(7'(p.weekday), 7'(t.weekday), 7'h0F) &&
		       field_ok(7'(p.hour), 7'(t.hour), 7'h3F) &&
		       field_ok(p.minute, t.minute, 7'h7F);
	endfunction

	// Applies one accepted word to the mirror and queues the words it fires.
	task automatic advance_alarm_table(input alarm_word_t w);
		alarm_hit_t hits[ENTRIES];
		int n;
		int scan;
		logic [HOLDOFF_W:0] count;
		n = 0;
		if (w.kind == KIND_LOAD) begin
			pat_tbl[w.slot] = w.t;
			type_tbl[w.slot] = w.mtype;
			fired_tbl[w.slot] = 1'b0;
			hold_tbl[w.slot] = '0;
			return;
		end
		scan = (int'(active_reg) > ENTRIES) ? ENTRIES : int'(active_reg);
		for (int i = 0; i < scan; i++) begin
			if (fired_tbl[i]) begin
				count = {1'b0, hold_tbl[i]} + 1'b1;
				if (count > {1'b0, holdoff_reg}) begin
					hold_tbl[i] = '0;
					fired_tbl[i] = 1'b0;
				end else begin
					hold_tbl[i] = count[HOLDOFF_W-1:0];
				end
			end else if (alarm_due(pat_tbl[i], w.t)) begin
				hits[n].idx = IDX_W'(i);
				hits[n].mtype = type_tbl[i];
				hits[n].last = 1'b0;
				n++;
				hold_tbl[i] = '0;
				fired_tbl[i] = 1'b1;
			end
		end
		for (int k = 0; k < n; k++) begin
			if (k == n - 1)
				hits[k].last = 1'b1;
			fired_due = {fired_due, hits[k]};
		end
	endtask

	function automatic alarm_word_t make_word(bit k, int slot, int mo, int d, int wd, int h,
			int mi, int mt);
		alarm_word_t w;
		w.kind = k;
		w.slot = IDX_W'(slot);
		w.t.month = 5'(mo);
		w.t.day = 6'(d);
		w.t.weekday = 4'(wd);
		w.t.hour = 6'(h);
		w.t.minute = 7'(mi);
		w.mtype = TYPE_W'(mt);
		return w;
	endfunction

	// Alarm fields lean towards wildcards so that ticks fire often.
	function automatic logic [6:0] alarm_field(int hi, logic [6:0] ones);
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return ones;
		else if (r < 9)
			return 7'($urandom_range(0, hi));
		return 7'($urandom) & ones;
	endfunction

	function automatic logic [6:0] clock_field(int hi, logic [6:0] ones);
		if ($urandom_range(0, 9) < 9)
			return 7'($urandom_range(0, hi));
		return 7'($urandom) & ones;
	endfunction

	function automatic wats_time_t random_pattern();
		wats_time_t p;
		p.month = 5'(alarm_field(12, 7'h1F));
		p.day = 6'(alarm_field(31, 7'h3F));
		p.weekday = 4'(alarm_field(6, 7'h0F));
		p.hour = 6'(alarm_field(23, 7'h3F));
		p.minute = alarm_field(59, 7'h7F);
		return p;
	endfunction

	function automatic wats_time_t random_time();
		wats_time_t t;
		t.month = 5'(clock_field(12, 7'h1F));
		t.day = 6'(clock_field(31, 7'h3F));
		t.weekday = 4'(clock_field(6, 7'h0F));
		t.hour = 6'(clock_field(23, 7'h3F));
		t.minute = clock_field(59, 7'h7F);
		return t;
	endfunction

	// A time that satisfies the given alarm, wildcards filled in at random.
	function automatic wats_time_t time_for(wats_time_t p);
		wats_time_t t;
		t = random_time();
		if (p.month != '1) t.month = p.month;
		if (p.day != '1) t.day = p.day;
		if (p.weekday != '1) t.weekday = p.weekday;
		if (p.hour != '1) t.hour = p.hour;
		if (p.minute != '1) t.minute = p.minute;
		return t;
	endfunction

	function automatic alarm_word_t make_random_word();
		alarm_word_t w;
		int r;
		int scan;
		w.slot = IDX_W'($urandom);
		w.mtype = TYPE_W'($urandom);
		w.t = random_time();
		scan = (int'(active_reg) > ENTRIES) ? ENTRIES : int'(active_reg);
		r = $urandom_range(0, 99);
		if (r < 22) begin
			w.kind = KIND_LOAD;
			w.t = random_pattern();
		end else begin
			w.kind = KIND_TICK;
			if (r < 78 && scan > 0) begin
				w.t = time_for(pat_tbl[$urandom_range(0, scan - 1)]);
				if ($urandom_range(0, 6) == 0)
					w.t.minute = w.t.minute + 1'b1;
			end
		end
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Sends one word and returns at the edge that accepts it, start still high.
	task automatic send_word(input alarm_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= w.kind;
		entry_index <= w.slot;
		month <= w.t.month;
		day <= w.t.day;
		weekday <= w.t.weekday;
		hour <= w.t.hour;
		minute <= w.t.minute;
		message_type <= w.mtype;
		@(posedge clk);
		while (busy) @(posedge clk);
		advance_alarm_table(w);
	endtask

	// A tick that fires nothing may still be scanning, hence the extra pause.
	task automatic quiesce();
		start <= 1'b0;
		while (fired_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == CFG_ACTIVE)
			active_reg = data;
		else if (idx == CFG_HOLDOFF)
			holdoff_reg = data;
	endtask

	task automatic set_config(input int active, input int holdoff);
		quiesce();
		write_reg(CFG_ACTIVE, CFG_DATA_W'(active));
		write_reg(CFG_HOLDOFF, CFG_DATA_W'(holdoff));
		cfg_valid <= 1'b0;
	endtask

	// Out of reset no entry is scanned, so a tick fires nothing.
	task automatic test_reset_state();
		send_word(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_directed_matches();
		send_word(make_word(KIND_LOAD, 0, -1, -1, -1, -1, -1, 8'h00));
		send_word(make_word(KIND_LOAD, 1, 12, 31, 6, 23, 59, 8'hFF));
		send_word(make_word(KIND_LOAD, 2, 0, 0, 0, 0, 0, 8'h01));
		send_word(make_word(KIND_LOAD, 3, 1, 1, -1, -1, -1, 8'hA5));
		quiesce();
		write_reg(CFG_ACTIVE, CFG_DATA_W'(4));
		cfg_valid <= 1'b0;
		// Holdoff stays at its reset value here.
		send_word(make_word(KIND_TICK, 15, 12, 31, 6, 23, 59, 8'hFF));
		send_word(make_word(KIND_TICK, 15, 0, 0, 0, 0, 0, 8'hFF));
		send_word(make_word(KIND_TICK, 0, 1, 1, 3, 10, 30, 8'h00));
		send_word(make_word(KIND_TICK, 7, 5, 5, 5, 5, 5, 8'h3C));
		send_word(make_word(KIND_TICK, 15, -1, -1, -1, -1, -1, 8'hFF));
	endtask

	task automatic test_holdoff();
		set_config(4, 0);
		repeat (3) send_word(make_word(KIND_TICK, 0, 12, 31, 6, 23, 59, 0));
		send_word(make_word(KIND_LOAD, 1, 12, 31, 6, 23, 59, 8'h5A));
		send_word(make_word(KIND_TICK, 0, 12, 31, 6, 23, 59, 0));
	endtask

	task automatic test_fill_table();
		alarm_word_t w;
		for (int s = 4; s < ENTRIES; s++) begin
			w = make_random_word();
			w.kind = KIND_LOAD;
			w.slot = IDX_W'(s);
			w.t = random_pattern();
			send_word(w);
		end
	endtask

	task automatic test_active_limits();
		set_config(31, 1);
		send_word(make_word(KIND_TICK, 0, 3, 9, 2, 14, 45, 0));
		send_word(make_word(KIND_TICK, 0, 3, 9, 2, 14, 45, 0));
		// Writes to the unused register indexes must change nothing.
		quiesce();
		write_reg(CFG_SPARE_LO, '1);
		write_reg(CFG_SPARE_HI, '0);
		cfg_valid <= 1'b0;
		send_word(make_word(KIND_TICK, 0, 3, 9, 2, 14, 45, 0));
		set_config(0, 31);
		send_word(make_word(KIND_TICK, 0, 3, 9, 2, 14, 45, 0));
	endtask

	task automatic test_random();
		int active;
		int holdoff;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin active = 16; holdoff = 0; end
				1: begin active = $urandom_range(1, 16); holdoff = 2; end
				2: begin active = 31; holdoff = 31; end
				3: begin active = 1; holdoff = $urandom_range(0, 5); end
				4: begin active = $urandom_range(17, 31); holdoff = 1; end
				default: begin active = $urandom_range(8, 16); holdoff = 3; end
			endcase
			set_config(active, holdoff);
			no_gaps = (ph % 3 == 2);
			repeat (PHASE_WORDS) send_word(make_random_word());
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (fired_due.size() == 0) begin
				$display("%0t: unexpected fired word: index %0d type %0d last %0d", $time,
					fired_index, fired_type, last);
				mismatches++;
			end else begin
				head = fired_due.pop_front();
				if (fired_index !== head.idx) begin
					$display("%0t: fired_index expected %0d actual %0d", $time, head.idx,
						fired_index);
					mismatches++;
				end
				if (fired_type !== head.mtype) begin
					$display("%0t: fired_type expected %0d actual %0d", $time, head.mtype,
						fired_type);
					mismatches++;
				end
				if (last !== head.last) begin
					$display("%0t: last expected %0d actual %0d", $time, head.last, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, nothing moved for %0d cycles", $time,
				WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			pat_tbl[i] = '0;
			type_tbl[i] = '0;
			fired_tbl[i] = 1'b0;
			hold_tbl[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed_matches();
		test_holdoff();
		test_fill_table();
		test_active_limits();
		test_random();
		start <= 1'b0;
		while (fired_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
